// ----- rtl/svs_pkg.sv -----
// ----------------------------------------------------------------------------
// svs_pkg
// Shared widths, codes, scoring constants and pipeline types of the stream
// variant selector.
// ----------------------------------------------------------------------------
package svs_pkg;

  // field widths
  localparam int IDX_W    = 4;
  localparam int CODEC_W  = 3;
  localparam int HEIGHT_W = 16;
  localparam int BW_W     = 31;
  localparam int FPS_W    = 10;
  localparam int SCORE_W  = 25;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 2;

  // codec codes
  localparam logic [CODEC_W-1:0] CODEC_H264 = 3'd0;
  localparam logic [CODEC_W-1:0] CODEC_HEVC = 3'd1;
  localparam logic [CODEC_W-1:0] CODEC_VP9  = 3'd2;
  localparam logic [CODEC_W-1:0] CODEC_AV1  = 3'd3;

  // selection modes
  localparam logic [MODE_W-1:0] MODE_SCORE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FMP4   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH_CAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIMIT  = 2'd2;

  localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT_RESET = 16'd720;

  // score terms
  localparam logic [SCORE_W-1:0] PEN_HEVC       = 25'd700000;
  localparam logic [SCORE_W-1:0] PEN_VP9        = 25'd800000;
  localparam logic [SCORE_W-1:0] PEN_AV1        = 25'd1000000;
  localparam logic [SCORE_W-1:0] PEN_OTHER      = 25'd250000;
  localparam logic [SCORE_W-1:0] PEN_TALL       = 25'd3000000;
  localparam logic [SCORE_W-1:0] PEN_NO_HEIGHT  = 25'd20000;
  localparam logic [SCORE_W-1:0] PEN_HIGH_FPS   = 25'd25000;
  localparam logic [HEIGHT_W-1:0] HEIGHT_HD     = 16'd1080;
  localparam logic [FPS_W-1:0]   FPS_NORMAL     = 10'd30;
  localparam logic [BW_W-1:0]    BW_EXCESS_BASE = 31'd12000000;
  localparam logic [BW_W-1:0]    BW_FLOOR_BASE  = 31'd10000000;
  localparam logic [BW_W-1:0]    BW_START_MAX   = 31'd2500000;
  localparam logic [BW_W-1:0]    BW_FMP4_HIGH   = 31'd10000000;
  localparam logic [BW_W-1:0]    BW_FMP4_LOW    = 31'd4000000;

  // reciprocal multipliers: x / 100 for x < 2^31, y / 100000 for y < 2^24
  localparam int FLOOR_W = 24;
  localparam logic [31:0] RECIP_100     = 32'd2748779070;
  localparam int          RECIP_100_SH  = 38;
  localparam logic [24:0] RECIP_100K    = 25'd21990233;
  localparam int          RECIP_100K_SH = 41;

  // scored item travelling from the scoring stage to the tracker
  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [HEIGHT_W-1:0] height;
    logic [BW_W-1:0]     bandwidth;
    logic                score_ok;
    logic                h264_low;
    logic                h264_rate;
    logic                tall_ok;
    logic [MODE_W-1:0]   mode;
    logic                last;
  } svs_item_t;

  // selection result
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             found;
  } svs_result_t;

endpackage

// ----- rtl/svs_score.sv -----
// ----------------------------------------------------------------------------
// svs_score
// Penalty score and qualification flags of one variant descriptor.
// ----------------------------------------------------------------------------
module svs_score (
  input  logic [svs_pkg::CODEC_W-1:0]  codec,
  input  logic [svs_pkg::HEIGHT_W-1:0] height,
  input  logic [svs_pkg::BW_W-1:0]     bandwidth,
  input  logic [svs_pkg::FPS_W-1:0]    frame_rate,
  input  logic                         last_variant,
  input  logic [svs_pkg::MODE_W-1:0]   mode,
  input  logic [svs_pkg::BW_W-1:0]     bandwidth_cap,
  input  logic [svs_pkg::HEIGHT_W-1:0] height_limit,
  output svs_pkg::svs_item_t           item
);
  import svs_pkg::*;

  logic [SCORE_W-1:0]  codec_term;
  logic [SCORE_W-1:0]  height_term;
  logic [SCORE_W-1:0]  excess_term;
  logic [SCORE_W-1:0]  fps_term;
  logic [SCORE_W-1:0]  floor_term;
  logic [HEIGHT_W-1:0] height_gap;
  logic [BW_W-1:0]     excess;
  logic [62:0]         excess_prod;
  logic [FLOOR_W-1:0]  floor_bw;
  logic [FLOOR_W-1:0]  floor_gap;
  logic [48:0]         floor_prod;
  logic [BW_W-1:0]     fmp4_cap;
  logic                is_h264;
  logic                capped;

  // codec penalty
  always_comb begin
    unique case (codec)
      CODEC_H264: codec_term = '0;
      CODEC_HEVC: codec_term = PEN_HEVC;
      CODEC_VP9:  codec_term = PEN_VP9;
      CODEC_AV1:  codec_term = PEN_AV1;
      default:    codec_term = PEN_OTHER;
    endcase
  end

  // height penalty, quarter of the gap below 1080 lines
  assign height_gap = HEIGHT_HD - height;
  always_comb begin
    if (height > HEIGHT_HD) begin
      height_term = PEN_TALL;
    end else if (height == '0) begin
      height_term = PEN_NO_HEIGHT;
    end else begin
      height_term = SCORE_W'(height_gap[HEIGHT_W-1:2]);
    end
  end

  // excess bandwidth above 12 Mbit/s, divided by 100
  assign excess      = bandwidth - BW_EXCESS_BASE;
  assign excess_prod = 63'(excess) * 63'(RECIP_100);
  assign excess_term = (bandwidth > BW_EXCESS_BASE) ?
                       excess_prod[62:RECIP_100_SH] : '0;

  // high frame rate penalty
  assign fps_term = (frame_rate > FPS_NORMAL) ? PEN_HIGH_FPS : '0;

  // low bandwidth penalty, gap below 10 Mbit/s divided by 100000
  assign floor_bw   = (bandwidth < BW_FLOOR_BASE) ? bandwidth[FLOOR_W-1:0] :
                      BW_FLOOR_BASE[FLOOR_W-1:0];
  assign floor_gap  = BW_FLOOR_BASE[FLOOR_W-1:0] - floor_bw;
  assign floor_prod = 49'(floor_gap) * 49'(RECIP_100K);
  assign floor_term = SCORE_W'(floor_prod[48:RECIP_100K_SH]);

  // qualification flags
  assign is_h264  = (codec == CODEC_H264);
  assign capped   = (mode == MODE_SCORE) && (bandwidth_cap != '0) &&
                    (bandwidth >= bandwidth_cap);
  assign fmp4_cap = (height_limit > HEIGHT_LIMIT_RESET) ? BW_FMP4_HIGH : BW_FMP4_LOW;

  always_comb begin
    item.score     = codec_term + height_term + excess_term + fps_term + floor_term;
    item.height    = height;
    item.bandwidth = bandwidth;
    item.score_ok  = !capped;
    item.h264_low  = is_h264 && (height <= HEIGHT_HD);
    item.h264_rate = is_h264 && (height <= HEIGHT_HD) && (bandwidth != '0) &&
                     (bandwidth <= BW_START_MAX);
    item.tall_ok   = is_h264 && (height != '0) && (height <= height_limit) &&
                     (bandwidth != '0) && (bandwidth <= fmp4_cap);
    item.mode      = mode;
    item.last      = last_variant;
  end

endmodule

// ----- rtl/svs_track.sv -----
// ----------------------------------------------------------------------------
// svs_track
// Running bests over one variant list and the final choice at its last item.
// ----------------------------------------------------------------------------
module svs_track #(
  parameter int MAX_VARIANTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  svs_pkg::svs_item_t  item,
  output svs_pkg::svs_result_t res
);
  import svs_pkg::*;

  localparam int CNT_W = $clog2(MAX_VARIANTS + 1);

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       score_idx_r, score_idx_nxt;
  logic [SCORE_W-1:0]     score_val_r, score_val_nxt;
  logic                   score_vld_r, score_vld_nxt;
  logic [IDX_W-1:0]       low_idx_r, low_idx_nxt;
  logic [BW_W-1:0]        low_bw_r, low_bw_nxt;
  logic                   low_vld_r, low_vld_nxt;
  logic [IDX_W-1:0]       h264_idx_r, h264_idx_nxt;
  logic [BW_W-1:0]        h264_bw_r, h264_bw_nxt;
  logic                   h264_vld_r, h264_vld_nxt;
  logic [IDX_W-1:0]       tall_idx_r, tall_idx_nxt;
  logic [HEIGHT_W-1:0]    tall_h_r, tall_h_nxt;
  logic [BW_W-1:0]        tall_bw_r, tall_bw_nxt;
  logic                   tall_vld_r, tall_vld_nxt;
  logic [CNT_W+IDX_W-1:0] cnt_ext;
  logic [IDX_W-1:0]       idx;
  logic                   room;

  assign room    = (cnt_r < CNT_W'(MAX_VARIANTS));
  assign cnt_ext = {{IDX_W{1'b0}}, cnt_r};
  assign idx     = cnt_ext[IDX_W-1:0];

  // update the running bests with the current item
  always_comb begin
    cnt_nxt       = cnt_r;
    score_idx_nxt = score_idx_r;
    score_val_nxt = score_val_r;
    score_vld_nxt = score_vld_r;
    low_idx_nxt   = low_idx_r;
    low_bw_nxt    = low_bw_r;
    low_vld_nxt   = low_vld_r;
    h264_idx_nxt  = h264_idx_r;
    h264_bw_nxt   = h264_bw_r;
    h264_vld_nxt  = h264_vld_r;
    tall_idx_nxt  = tall_idx_r;
    tall_h_nxt    = tall_h_r;
    tall_bw_nxt   = tall_bw_r;
    tall_vld_nxt  = tall_vld_r;
    if (go && room) begin
      cnt_nxt = cnt_r + 1'b1;
      if (item.score_ok && (!score_vld_r || (item.score < score_val_r))) begin
        score_idx_nxt = idx;
        score_val_nxt = item.score;
        score_vld_nxt = 1'b1;
      end
      if (item.h264_rate && (!h264_vld_r || (item.bandwidth > h264_bw_r))) begin
        h264_idx_nxt = idx;
        h264_bw_nxt  = item.bandwidth;
        h264_vld_nxt = 1'b1;
      end
      if (item.h264_low && (!low_vld_r ||
          ((item.bandwidth != '0) && (item.bandwidth < low_bw_r)))) begin
        low_idx_nxt = idx;
        low_bw_nxt  = item.bandwidth;
        low_vld_nxt = 1'b1;
      end
      if (item.tall_ok && (!tall_vld_r || (item.height > tall_h_r) ||
          ((item.height == tall_h_r) && (item.bandwidth > tall_bw_r)))) begin
        tall_idx_nxt = idx;
        tall_h_nxt   = item.height;
        tall_bw_nxt  = item.bandwidth;
        tall_vld_nxt = 1'b1;
      end
    end
  end

  // final choice from the updated bests
  always_comb begin
    res = '0;
    unique case (item.mode)
      MODE_START: begin
        res.found = 1'b1;
        if (h264_vld_nxt) begin
          res.idx = h264_idx_nxt;
        end else if (low_vld_nxt) begin
          res.idx = low_idx_nxt;
        end else if (score_vld_nxt) begin
          res.idx = score_idx_nxt;
        end
      end
      MODE_FMP4: begin
        res.found = tall_vld_nxt;
        res.idx   = tall_vld_nxt ? tall_idx_nxt : '0;
      end
      default: begin
        res.found = score_vld_nxt;
        res.idx   = score_vld_nxt ? score_idx_nxt : '0;
      end
    endcase
  end

  // state registers, cleared after the last item of a list
  always_ff @(posedge clk) begin
    if (!rst_n || (go && item.last)) begin
      cnt_r       <= '0;
      score_idx_r <= '0;
      score_val_r <= '1;
      score_vld_r <= 1'b0;
      low_idx_r   <= '0;
      low_bw_r    <= '0;
      low_vld_r   <= 1'b0;
      h264_idx_r  <= '0;
      h264_bw_r   <= '0;
      h264_vld_r  <= 1'b0;
      tall_idx_r  <= '0;
      tall_h_r    <= '0;
      tall_bw_r   <= '0;
      tall_vld_r  <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      score_idx_r <= score_idx_nxt;
      score_val_r <= score_val_nxt;
      score_vld_r <= score_vld_nxt;
      low_idx_r   <= low_idx_nxt;
      low_bw_r    <= low_bw_nxt;
      low_vld_r   <= low_vld_nxt;
      h264_idx_r  <= h264_idx_nxt;
      h264_bw_r   <= h264_bw_nxt;
      h264_vld_r  <= h264_vld_nxt;
      tall_idx_r  <= tall_idx_nxt;
      tall_h_r    <= tall_h_nxt;
      tall_bw_r   <= tall_bw_nxt;
      tall_vld_r  <= tall_vld_nxt;
    end
  end

endmodule

// ----- rtl/stream_variant_selector_top.sv -----
// ----------------------------------------------------------------------------
// stream_variant_selector_top
// Picks one variant out of a list of stream variant descriptors.
// ----------------------------------------------------------------------------
// Usage: variant descriptors enter on the in_ stream, one per transaction,
// in arrival order; in_tlast marks the final variant of a list. For each
// list one result leaves on the out_ stream: the chosen arrival index in
// out_tdata and the found flag in out_tuser. Items without in_tlast give no
// result. The cfg_ channel writes select_mode (0), bandwidth_cap (1) and
// height_limit (2); the user must do so only while the block is idle (not
// enforced by the block); cfg_ready is always high. Throughput: one item
// per cycle unless a last item waits on a full result register. Path: input
// register, scoring stage (two reciprocal multipliers and a five term sum),
// scored item register, tracker compare, result register (three register
// stages in all); out_tvalid comes from the result register. Reset: all
// list state clears, select_mode and bandwidth_cap return to 0 and
// height_limit to 720. Only the first MAX_VARIANTS items of a list enter
// the running bests; later ones still end the list when marked last.
// Stall: a result waits in the output register; items keep flowing until a
// further last item reaches the tracker, then in_tready drops.
// ----------------------------------------------------------------------------
module stream_variant_selector_top #(
  parameter int MAX_VARIANTS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // codec [2:0], height [18:3], bandwidth [49:19], frame_rate [59:50]
  input  logic [63:0]                      in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // chosen_index [3:0]
  output logic [7:0]                       out_tdata,
  // found [0]
  output logic                             out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [svs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svs_pkg::BW_W-1:0]         cfg_data
);
  import svs_pkg::*;

  logic [MODE_W-1:0]   select_mode_r;
  logic [BW_W-1:0]     bandwidth_cap_r;
  logic [HEIGHT_W-1:0] height_limit_r;
  logic [MODE_W-1:0]   mode_eff;

  logic                a_valid_r;
  logic [59:0]         a_data_r;
  logic                a_last_r;
  logic                b_valid_r;
  svs_item_t           b_item_r;
  svs_item_t           scored;
  logic                out_valid_r;
  svs_result_t         out_res_r;
  svs_result_t         track_res;

  logic                in_accept;
  logic                out_free;
  logic                a_go;
  logic                b_go;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_mode_r   <= MODE_SCORE;
      bandwidth_cap_r <= '0;
      height_limit_r  <= HEIGHT_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SELECT_MODE:   select_mode_r   <= cfg_data[MODE_W-1:0];
        CFG_BANDWIDTH_CAP: bandwidth_cap_r <= cfg_data;
        CFG_HEIGHT_LIMIT:  height_limit_r  <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign mode_eff = (select_mode_r == MODE_UNUSED) ? MODE_SCORE : select_mode_r;

  // pipeline flow control
  assign out_free  = !out_valid_r || out_tready;
  assign b_go      = b_valid_r && (!b_item_r.last || out_free);
  assign a_go      = a_valid_r && (!b_valid_r || b_go);
  assign in_tready = !a_valid_r || a_go;
  assign in_accept = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_accept) begin
      a_valid_r <= 1'b1;
    end else if (a_go) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_data_r <= in_tdata[59:0];
      a_last_r <= in_tlast;
    end
  end

  // scoring
  svs_score u_score (
    .codec         (a_data_r[2:0]),
    .height        (a_data_r[18:3]),
    .bandwidth     (a_data_r[49:19]),
    .frame_rate    (a_data_r[59:50]),
    .last_variant  (a_last_r),
    .mode          (mode_eff),
    .bandwidth_cap (bandwidth_cap_r),
    .height_limit  (height_limit_r),
    .item          (scored)
  );

  // scored item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_go) begin
      b_valid_r <= 1'b1;
    end else if (b_go) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_item_r <= scored;
    end
  end

  // running bests
  svs_track #(
    .MAX_VARIANTS (MAX_VARIANTS)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (b_go),
    .item  (b_item_r),
    .res   (track_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_go && b_item_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_item_r.last) begin
      out_res_r <= track_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - IDX_W){1'b0}}, out_res_r.idx};
  assign out_tuser  = out_res_r.found;

`ifndef SYNTH
  // no variant found means index zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[IDX_W-1:0] == '0)
    else $error("result without a variant carries a nonzero index");

  // start variant mode always reports a selection
  a_start_found: assert property (@(posedge clk) disable iff (!rst_n)
    b_go && b_item_r.last && (b_item_r.mode == MODE_START) |=> out_tvalid && out_tuser)
    else $error("start variant mode result lost or not found");

  // a last item blocked by a full result register stays put
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_item_r.last && !out_free |=> b_valid_r && b_item_r.last)
    else $error("blocked last item left the tracker stage");

  // an empty input register always takes a transaction
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !a_valid_r |-> in_tready)
    else $error("input stalled with an empty input register");
`endif

endmodule
